// File: hdl/ialu_pkg.sv
// Shared types and constants for the integer ALU with floored modulus and power.
// Holds the operation codes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ialu_pkg;

    // Default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // Bits of the multiplier operand consumed per multiply step
    localparam int MUL_CHUNK = 16;

    // Width of the operation code
    localparam int OP_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_DIV  = 5'd3,
        OP_MOD  = 5'd4,
        OP_POW  = 5'd5,
        OP_AND  = 5'd6,
        OP_OR   = 5'd7,
        OP_XOR  = 5'd8,
        OP_SHL  = 5'd9,
        OP_SHR  = 5'd10,
        OP_SAR  = 5'd11,
        OP_EQ   = 5'd12,
        OP_LT   = 5'd13,
        OP_GT   = 5'd14,
        OP_GE   = 5'd15,
        OP_LE   = 5'd16,
        OP_NE   = 5'd17,
        OP_SELB = 5'd18
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_POW_CHECK,
        ST_POW_MUL,
        ST_POW_UPD,
        ST_FINISH
    } state_t;

    // Source of the value captured into the output register
    typedef enum logic [2:0] {
        RES_SIMPLE,
        RES_DIV,
        RES_MOD,
        RES_MULP,
        RES_POW,
        RES_ZERO,
        RES_ONE
    } res_sel_t;

    // Multiplier operand sources
    typedef enum logic {
        MUL_SRC_AB,
        MUL_SRC_POW
    } mul_src_t;

    typedef struct packed {
        logic     load;
        logic     div_init;
        logic     div_step;
        logic     mul_start;
        mul_src_t mul_src;
        logic     mul_step;
        logic     pow_init;
        logic     pow_update;
        logic     capture;
        res_sel_t res_sel;
    } ialu_cmd_t;

    typedef struct packed {
        op_t  op;
        logic base_zero;
        logic base_one;
        logic base_mone;
        logic exp_neg;
        logic exp_zero;
        logic out_free;
    } ialu_status_t;

endpackage

`default_nettype wire

// File: hdl/ialu_ctrl.sv
// Controller of the integer ALU: sequences setup, division, multiply and power.
// Depends on ialu_pkg; drives the datapath through ialu_cmd_t only.
`timescale 1ns / 1ps
`default_nettype none

module ialu_ctrl import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire ialu_status_t status,
    output ialu_cmd_t         cmd
);

    localparam int CH     = (MUL_CHUNK < DATA_WIDTH) ? MUL_CHUNK : DATA_WIDTH;
    localparam int NCHUNK = (DATA_WIDTH + CH - 1) / CH;
    localparam int CNT_W  = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_WIDTH - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NCHUNK - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    res_sel_t         sel_reg, sel_next;

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold the chosen result source until capture
    always_ff @(posedge aclk) begin
        sel_reg <= sel_next;
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.res_sel = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cnt_next = '0;
                case (status.op)
                    OP_DIV, OP_MOD: begin
                        cmd.div_init = 1'b1;
                        sel_next     = (status.op == OP_DIV) ? RES_DIV : RES_MOD;
                        state_next   = ST_DIV;
                    end
                    OP_MUL: begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_src   = MUL_SRC_AB;
                        sel_next      = RES_MULP;
                        state_next    = ST_MUL;
                    end
                    OP_POW: begin
                        if (status.base_zero) begin
                            sel_next   = RES_ZERO;
                            state_next = ST_FINISH;
                        end else if (status.base_one) begin
                            sel_next   = RES_ONE;
                            state_next = ST_FINISH;
                        end else if (status.exp_neg && !status.base_mone) begin
                            sel_next   = RES_ZERO;
                            state_next = ST_FINISH;
                        end else begin
                            cmd.pow_init = 1'b1;
                            sel_next     = RES_POW;
                            state_next   = ST_POW_CHECK;
                        end
                    end
                    default: begin
                        sel_next   = RES_SIMPLE;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_FINISH;
                end
            end
            ST_POW_CHECK: begin
                cnt_next = '0;
                if (status.exp_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_src   = MUL_SRC_POW;
                    state_next    = ST_POW_MUL;
                end
            end
            ST_POW_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_POW_UPD;
                end
            end
            ST_POW_UPD: begin
                cmd.pow_update = 1'b1;
                state_next     = ST_POW_CHECK;
            end
            ST_FINISH: begin
                // Wait for the output register to free up
                if (status.out_free) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/ialu_dp.sv
// Datapath of the integer ALU: operand registers, combinational ops, restoring
// divider, chunked multipliers, power registers and the output register.
// Depends on ialu_pkg; steered by ialu_ctrl through ialu_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ialu_dp import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ialu_cmd_t             cmd,
    output ialu_status_t               status,
    input  wire logic [OP_W-1:0]       in_op,
    input  wire logic [DATA_WIDTH-1:0] in_left,
    input  wire logic [DATA_WIDTH-1:0] in_right,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DATA_WIDTH-1:0]      out_result
);

    localparam int W  = DATA_WIDTH;
    localparam int CH = (MUL_CHUNK < W) ? MUL_CHUNK : W;
    localparam logic [W-1:0] ONE_W = W'(1);

    // Operands
    op_t          op_reg;
    logic [W-1:0] a_reg, b_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= op_t'(in_op);
            a_reg  <= in_left;
            b_reg  <= in_right;
        end
    end

    logic         a_neg, b_neg, b_zero;
    logic [W-1:0] a_mag, b_mag;

    assign a_neg  = a_reg[W-1];
    assign b_neg  = b_reg[W-1];
    assign b_zero = (b_reg == '0);
    assign a_mag  = a_neg ? (W'(0) - a_reg) : a_reg;
    assign b_mag  = b_neg ? (W'(0) - b_reg) : b_reg;

    // Combinational operations
    logic [4:0]   amt;
    logic [W-1:0] simple_res;

    assign amt = b_reg[4:0];

    always_comb begin
        case (op_reg)
            OP_ADD:  simple_res = a_reg + b_reg;
            OP_SUB:  simple_res = a_reg - b_reg;
            OP_AND:  simple_res = a_reg & b_reg;
            OP_OR:   simple_res = a_reg | b_reg;
            OP_XOR:  simple_res = a_reg ^ b_reg;
            OP_SHL:  simple_res = a_reg << amt;
            OP_SHR:  simple_res = a_reg >> amt;
            OP_SAR:  simple_res = W'($signed(a_reg) >>> amt);
            OP_EQ:   simple_res = W'(a_reg == b_reg);
            OP_LT:   simple_res = W'($signed(a_reg) < $signed(b_reg));
            OP_GT:   simple_res = W'($signed(b_reg) < $signed(a_reg));
            OP_GE:   simple_res = W'(!($signed(a_reg) < $signed(b_reg)));
            OP_LE:   simple_res = W'(!($signed(b_reg) < $signed(a_reg)));
            OP_NE:   simple_res = W'(a_reg != b_reg);
            OP_SELB: simple_res = b_reg;
            default: simple_res = a_reg;
        endcase
    end

    // Restoring divider on magnitudes, one quotient bit per step
    logic [W-1:0] dv_rem_reg, dv_quo_reg, dv_den_reg;
    logic [W:0]   dv_shift, dv_diff;

    assign dv_shift = {dv_rem_reg, dv_quo_reg[W-1]};
    assign dv_diff  = dv_shift - {1'b0, dv_den_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dv_rem_reg <= '0;
            dv_quo_reg <= a_mag;
            dv_den_reg <= b_mag;
        end else if (cmd.div_step) begin
            dv_rem_reg <= dv_diff[W] ? dv_shift[W-1:0] : dv_diff[W-1:0];
            dv_quo_reg <= {dv_quo_reg[W-2:0], ~dv_diff[W]};
        end
    end

    // Sign fix-up: truncated quotient, floored remainder
    logic [W-1:0] div_res, rem_signed, mod_res;

    assign div_res    = b_zero ? '0 :
                        ((a_neg != b_neg) ? (W'(0) - dv_quo_reg) : dv_quo_reg);
    assign rem_signed = a_neg ? (W'(0) - dv_rem_reg) : dv_rem_reg;
    assign mod_res    = (b_zero || dv_rem_reg == '0) ? '0 :
                        ((a_neg != b_neg) ? (rem_signed + b_reg) : rem_signed);

    // Power state: accumulator, running base, exponent
    logic [W-1:0] pw_acc_reg, pw_base_reg, pw_exp_reg;

    // Two multipliers, one chunk of the multiplier operand per step
    logic [W-1:0] ma_x_reg, ma_y_reg, ma_p_reg;
    logic [W-1:0] mb_x_reg, mb_y_reg, mb_p_reg;
    logic [W-1:0] ma_term, mb_term;

    assign ma_term = ma_x_reg * W'(ma_y_reg[CH-1:0]);
    assign mb_term = mb_x_reg * W'(mb_y_reg[CH-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            ma_p_reg <= '0;
            mb_p_reg <= '0;
            if (cmd.mul_src == MUL_SRC_AB) begin
                ma_x_reg <= a_reg;
                ma_y_reg <= b_reg;
            end else begin
                ma_x_reg <= pw_acc_reg;
                ma_y_reg <= pw_base_reg;
            end
            mb_x_reg <= pw_base_reg;
            mb_y_reg <= pw_base_reg;
        end else if (cmd.mul_step) begin
            ma_p_reg <= ma_p_reg + ma_term;
            mb_p_reg <= mb_p_reg + mb_term;
            ma_x_reg <= ma_x_reg << CH;
            mb_x_reg <= mb_x_reg << CH;
            ma_y_reg <= ma_y_reg >> CH;
            mb_y_reg <= mb_y_reg >> CH;
        end
    end

    // Square-and-multiply update
    always_ff @(posedge aclk) begin
        if (cmd.pow_init) begin
            pw_acc_reg  <= ONE_W;
            pw_base_reg <= a_reg;
            pw_exp_reg  <= b_mag;
        end else if (cmd.pow_update) begin
            if (pw_exp_reg[0]) begin
                pw_acc_reg <= ma_p_reg;
            end
            pw_base_reg <= mb_p_reg;
            pw_exp_reg  <= pw_exp_reg >> 1;
        end
    end

    // Output register
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] res_reg, res_next;

    always_comb begin
        case (cmd.res_sel)
            RES_SIMPLE: res_next = simple_res;
            RES_DIV:    res_next = div_res;
            RES_MOD:    res_next = mod_res;
            RES_MULP:   res_next = ma_p_reg;
            RES_POW:    res_next = pw_acc_reg;
            RES_ONE:    res_next = ONE_W;
            default:    res_next = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    // Status to the controller
    always_comb begin
        status           = '0;
        status.op        = op_reg;
        status.base_zero = (a_reg == '0);
        status.base_one  = (a_reg == ONE_W);
        status.base_mone = (a_reg == '1);
        status.exp_neg   = b_neg;
        status.exp_zero  = (pw_exp_reg == '0);
        status.out_free  = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// File: hdl/integer_alu_floored_mod_pow.sv
// Integer ALU with truncated division, floored modulus and integer power.
// Slave channel: s_tuser carries the operation code, s_tdata the two operands.
// Master channel: m_tdata carries the result, held in an output register.
// One item is worked on at a time; the next is taken as soon as the
// controller is back in idle, even while the previous result still waits.
// Steps from acceptance to m_tvalid, with the multiply split into one step per
// 16-bit chunk of the multiplier operand:
//   combinational ops and power special cases: setup, finish
//   mul: setup, the multiply steps, finish
//   div, mod: setup, one quotient bit per cycle in the restoring divider, finish
//   pow: setup; per exponent magnitude bit a check, the multiply steps and an update
//        (one squaring and one accumulate multiply per bit); a last check; finish
// A new item is accepted in the cycle after the result is captured.
// If m_tready stays low, the finished result holds in the output register and
// the next result waits in the controller until the register frees up.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// any pending result. Depends on ialu_pkg, ialu_ctrl and ialu_dp.
`timescale 1ns / 1ps
`default_nettype none

module integer_alu_floored_mod_pow import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // fields from bit 0: left_value, right_value, zero fill
    input  wire logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // fields from bit 0: op
    input  wire logic [OP_W-1:0]         s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // fields from bit 0: result, zero fill
    output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    ialu_cmd_t               cmd;
    ialu_status_t            status;
    logic [DATA_WIDTH-1:0]   result;

    ialu_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    ialu_dp #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tuser),
        .in_left   (s_tdata[DATA_WIDTH-1:0]),
        .in_right  (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_result(result)
    );

    // Pad the result to whole bytes
    assign m_tdata = M_TDATA_W'(result);

endmodule

`default_nettype wire

// File: tb/integer_alu_floored_mod_pow_tb.sv
// Self-checking testbench for integer_alu_floored_mod_pow: directed and random items
// go through the stream ports under four idling phases and are checked against a predictor.
// Depends on ialu_pkg and the integer_alu_floored_mod_pow RTL.
`timescale 1ns / 1ps

module integer_alu_floored_mod_pow_tb import ialu_pkg::*; ();

    localparam int          DW        = 32;
    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
    localparam int          RAND_ITEMS = 440;
    // slowest item is a power with a 32-bit exponent magnitude
    localparam int          DRAIN_CYCLES = 300;
    localparam int          CYCLE_LIMIT  = 1_500_000;

    typedef struct {
        op_t         op;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] result;
    } alu_item_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*DW-1:0]     s_tdata  = '0;   // fields from bit 0: left_value, right_value
    logic [OP_W-1:0]     s_tuser  = '0;   // fields from bit 0: op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DW-1:0]       m_tdata;         // fields from bit 0: result

    alu_item_t op_queue[$];
    alu_item_t result_queue[$];
    alu_item_t in_flight;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        error_count = 0;
    int        cycle_count = 0;

    integer_alu_floored_mod_pow #(.DATA_WIDTH(DW)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Work out the result the ALU should give for one item
    function automatic logic [31:0] alu_result(op_t op, logic [31:0] a, logic [31:0] b);
        logic [31:0] mag_a, mag_b, quot, rem, expo, acc, base;
        logic [4:0]  amt;
        mag_a = a[31] ? -a : a;
        mag_b = b[31] ? -b : b;
        amt   = b[4:0];
        case (op)
            OP_ADD:  return a + b;
            OP_SUB:  return a - b;
            OP_MUL:  return a * b;
            OP_DIV: begin
                if (b == 0) return 0;
                quot = mag_a / mag_b;
                return (a[31] != b[31]) ? -quot : quot;
            end
            OP_MOD: begin
                if (b == 0) return 0;
                rem = mag_a % mag_b;
                if (rem == 0) return 0;
                if (a[31]) rem = -rem;
                // floored: shift a remainder of the wrong sign by the divisor
                if (a[31] != b[31]) rem = rem + b;
                return rem;
            end
            OP_POW: begin
                if (a == 0) return 0;
                if (a == 1) return 1;
                if (b[31]) begin
                    if (a != ALL_ONES) return 0;
                    expo = mag_b;
                end else begin
                    expo = b;
                end
                acc  = 1;
                base = a;
                while (expo != 0) begin
                    if (expo[0]) acc = acc * base;
                    base = base * base;
                    expo = expo >> 1;
                end
                return acc;
            end
            OP_AND:  return a & b;
            OP_OR:   return a | b;
            OP_XOR:  return a ^ b;
            OP_SHL:  return a << amt;
            OP_SHR:  return a >> amt;
            OP_SAR:  return $signed(a) >>> amt;
            OP_EQ:   return {31'b0, a == b};
            OP_LT:   return {31'b0, $signed(a) < $signed(b)};
            OP_GT:   return {31'b0, $signed(a) > $signed(b)};
            OP_GE:   return {31'b0, $signed(a) >= $signed(b)};
            OP_LE:   return {31'b0, $signed(a) <= $signed(b)};
            OP_NE:   return {31'b0, a != b};
            OP_SELB: return b;
            default: return a;
        endcase
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return ALL_ONES;
            3:       return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

    // Operands spread over full range, small values, extremes and varied magnitudes
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 40) - 20;
            6:          return pick_extreme();
            7, 8:       return $urandom >> $urandom_range(0, 31);
            default:    return ~($urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    // Exponents kept mostly short so power items stay quick
    function automatic logic [31:0] rand_exponent();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 40);
            6, 7:             return -$urandom_range(1, 20);
            8:                return $urandom;
            default:          return pick_extreme();
        endcase
    endfunction

    task automatic add_item(input op_t op, input logic [31:0] a, input logic [31:0] b);
        alu_item_t item;
        item.op     = op;
        item.lhs    = a;
        item.rhs    = b;
        item.result = '0;
        op_queue.push_back(item);
    endtask

    // Queue random items, then hold until every one has been answered
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        op_t         op;
        logic [31:0] a, b;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            op = op_t'($urandom_range(0, 18));
            a  = rand_operand();
            b  = (op == OP_POW) ? rand_exponent() : rand_operand();
            add_item(op, a, b);
        end
        while (op_queue.size() != 0 || s_tvalid || result_queue.size() != 0)
            @(posedge aclk);
    endtask

    // Stimulus and end of run
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        add_item(OP_ADD,  WORD_MAX, 32'd1);
        add_item(OP_SUB,  WORD_MIN, 32'd1);
        add_item(OP_MUL,  WORD_MIN, ALL_ONES);
        add_item(OP_MUL,  32'h0001_0003, 32'hfffe_0005);
        add_item(OP_DIV,  32'd1234, 32'd0);
        add_item(OP_DIV,  WORD_MIN, ALL_ONES);
        add_item(OP_DIV,  -32'd7, 32'd2);
        add_item(OP_MOD,  32'd1234, 32'd0);
        add_item(OP_MOD,  WORD_MIN, ALL_ONES);
        add_item(OP_MOD,  -32'd7, 32'd3);
        add_item(OP_MOD,  32'd7, -32'd3);
        add_item(OP_MOD,  -32'd6, 32'd3);
        add_item(OP_POW,  32'd0, -32'd5);
        add_item(OP_POW,  32'd1, WORD_MIN);
        add_item(OP_POW,  ALL_ONES, -32'd3);
        add_item(OP_POW,  ALL_ONES, WORD_MIN);
        add_item(OP_POW,  32'd2, ALL_ONES);
        add_item(OP_POW,  32'd3, WORD_MAX);
        add_item(OP_POW,  32'd5, 32'd0);
        add_item(OP_AND,  ALL_ONES, 32'ha5a5_5a5a);
        add_item(OP_OR,   32'h0f0f_0000, 32'h0000_f0f1);
        add_item(OP_XOR,  ALL_ONES, 32'h1234_5678);
        add_item(OP_SHL,  ALL_ONES, 32'd33);
        add_item(OP_SHR,  WORD_MIN, 32'd31);
        add_item(OP_SAR,  WORD_MIN, ALL_ONES);
        add_item(OP_EQ,   WORD_MIN, WORD_MIN);
        add_item(OP_LT,   WORD_MIN, WORD_MAX);
        add_item(OP_GT,   WORD_MIN, WORD_MAX);
        add_item(OP_GE,   ALL_ONES, ALL_ONES);
        add_item(OP_LE,   WORD_MAX, WORD_MIN);
        add_item(OP_NE,   32'd0, 32'd0);
        add_item(OP_SELB, WORD_MAX, WORD_MIN);

        run_phase(0,  0,  RAND_ITEMS);
        run_phase(69, 0,  RAND_ITEMS);
        run_phase(0,  69, RAND_ITEMS);
        run_phase(36, 36, RAND_ITEMS);

        // let anything stray come out before judging
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Driver: predict on acceptance, then present the next item or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_flight.result = alu_result(in_flight.op, in_flight.lhs, in_flight.rhs);
                result_queue.push_back(in_flight);
            end
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_flight = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {in_flight.rhs, in_flight.lhs};
                    s_tuser  <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: check each result against the oldest prediction
    always @(posedge aclk) begin
        alu_item_t exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_queue.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end else begin
                exp_item = result_queue.pop_front();
                if (m_tdata !== exp_item.result) begin
                    error_count++;
                    $display("%0t: %s a=%h b=%h result expected %h actual %h", $time,
                             exp_item.op.name(), exp_item.lhs, exp_item.rhs,
                             exp_item.result, m_tdata);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, result_queue.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// File: filelist.f
hdl/ialu_pkg.sv
hdl/ialu_ctrl.sv
hdl/ialu_dp.sv
hdl/integer_alu_floored_mod_pow.sv
tb/integer_alu_floored_mod_pow_tb.sv
